[rtl/gbv_pkg.sv]
// ----------------------------------------------------------------------------
// gbv_pkg
// Shared widths, constants, register indexes and the per-axis configuration
// bundle for the geofence barrier velocity block.
// ----------------------------------------------------------------------------
package gbv_pkg;

    // Margin added to the clearance test, Q16.16.
    localparam int unsigned EPS     = 655;
    localparam int unsigned EPS_W   = 10;

    // Field widths.
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LA_W    = 20;
    localparam int unsigned REG_W   = 31;
    localparam int unsigned IDX_W   = 3;

    // Divider geometry: one quotient bit per stage.
    localparam int unsigned QUO_W   = 32;
    localparam int unsigned NUM_W   = 64;
    localparam int unsigned DEN_W   = 72;

    // Pipeline depth: six front stages, the divider, one output stage.
    localparam int unsigned FRONT   = 6;
    localparam int unsigned LAT     = FRONT + QUO_W + 1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] IDX_LOOKAHEAD = 3'd0;
    localparam logic [IDX_W-1:0] IDX_CENTRE_X  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_CENTRE_Y  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_HALF_W    = 3'd3;
    localparam logic [IDX_W-1:0] IDX_INNER     = 3'd4;
    localparam logic [IDX_W-1:0] IDX_OUTER     = 3'd5;
    localparam logic [IDX_W-1:0] IDX_GAIN_X    = 3'd6;
    localparam logic [IDX_W-1:0] IDX_GAIN_Y    = 3'd7;

    // Clearance regions of one axis.
    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_NEAR = 2'd1;
    localparam logic [1:0] SEL_FLAT = 2'd2;
    localparam logic [1:0] SEL_RAMP = 2'd3;

    // Everything one axis needs from the register file.
    typedef struct packed {
        logic [LA_W-1:0]  lookahead;
        logic [REG_W-1:0] centre;
        logic [REG_W-1:0] half_width;
        logic [REG_W-1:0] inner;
        logic [REG_W-1:0] outer;
        logic [REG_W-1:0] gain;
    } t_axis_cfg;

endpackage

[rtl/gbv_axis.sv]
// ----------------------------------------------------------------------------
// gbv_axis
// One axis of the barrier: prediction, region test, products, and a
// restoring divider with one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module gbv_axis (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  gbv_pkg::t_axis_cfg            i_cfg,
    input  logic signed [31:0]            i_pos,
    input  logic signed [31:0]            i_vel,
    output logic signed [31:0]            o_push,
    output logic                          o_clip
);
    import gbv_pkg::*;

    // Stage 1: velocity times lookahead.
    logic signed [52:0] n1_m;
    logic signed [52:0] r1_m;
    logic signed [31:0] r1_pos;

    assign n1_m = $signed({1'b0, i_cfg.lookahead}) * i_vel;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m   <= n1_m;
            r1_pos <= i_pos;
        end
    end

    // Stage 2: predicted offset from the centre line and its magnitude.
    logic signed [37:0] n2_p;
    logic signed [38:0] n2_d;
    logic        [38:0] r2_a;
    logic               r2_dneg;

    assign n2_p = 38'(r1_pos) + 38'($signed(r1_m[52:16]));
    assign n2_d = 39'(n2_p) - $signed({8'd0, i_cfg.centre});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a    <= n2_d[38] ? 39'(-n2_d) : n2_d;
            r2_dneg <= n2_d[38];
        end
    end

    // Stage 3: region tests and the operands of the products.
    logic signed [40:0] s_a, s_rh, s_rm, s_ra, s_e, n3_h, n3_r, n3_rabs;
    logic signed [40:0] n3_g, n3_fac;
    logic               n3_far, n3_near, n3_flat, n3_rneg;
    logic [1:0]         n3_sel;
    logic [1:0]         r3_sel;
    logic [30:0]        r3_g, r3_rabs, r3_w;
    logic [33:0]        r3_fac;
    logic               r3_vneg, r3_dneg;

    assign s_a     = $signed({2'b00, r2_a});
    assign s_rh    = $signed({10'd0, i_cfg.half_width});
    assign s_rm    = $signed({10'd0, i_cfg.inner});
    assign s_ra    = $signed({10'd0, i_cfg.outer});
    assign s_e     = 41'(EPS);
    assign n3_h    = s_rh - s_a;
    assign n3_r    = s_rh - s_rm;
    assign n3_g    = n3_r - s_a;
    assign n3_fac  = (s_a <<< 1) + s_e + s_ra - s_rh;
    assign n3_rneg = n3_r[40];
    assign n3_rabs = n3_rneg ? -n3_r : n3_r;
    assign n3_far  = n3_h > s_ra;
    assign n3_near = n3_r >= s_a + s_e;
    assign n3_flat = (n3_h < s_rm) || (s_ra <= s_rm);

    always_comb begin
        priority if (n3_far) begin
            n3_sel = SEL_ZERO;
        end else if (n3_near) begin
            n3_sel = SEL_NEAR;
        end else if (n3_flat) begin
            n3_sel = SEL_FLAT;
        end else begin
            n3_sel = SEL_RAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sel  <= n3_sel;
            r3_g    <= n3_g[30:0];
            r3_fac  <= n3_fac[33:0];
            r3_rabs <= n3_rabs[30:0];
            r3_w    <= (n3_sel == SEL_RAMP) ? 31'(s_ra - s_rm) : 31'd1;
            r3_vneg <= (n3_sel == SEL_FLAT || n3_sel == SEL_RAMP) && n3_rneg;
            r3_dneg <= r2_dneg;
        end
    end

    // Stage 4: the three products, each on its own multiplier.
    logic [61:0] r4_gg, r4_wr;
    logic [64:0] n4_gf;
    logic [63:0] r4_gf;
    logic [1:0]  r4_sel;
    logic        r4_vneg, r4_dneg;

    assign n4_gf = 65'(i_cfg.gain) * 65'(r3_fac);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_gg   <= 62'(r3_g) * 62'(r3_g);
            r4_wr   <= 62'(r3_w) * 62'(r3_rabs);
            r4_gf   <= n4_gf[63:0];
            r4_sel  <= r3_sel;
            r4_vneg <= r3_vneg;
            r4_dneg <= r3_dneg;
        end
    end

    // Stage 5: numerator and divisor of the quotient for this region.
    logic [NUM_W-1:0] n5_p, r5_p;
    logic [DEN_W-1:0] n5_d, r5_d;
    logic             r5_vneg, r5_dneg;

    always_comb begin
        unique case (r4_sel)
            SEL_ZERO: begin
                n5_p = '0;
                n5_d = 72'(r4_gg);
            end
            SEL_NEAR: begin
                n5_p = 64'(i_cfg.gain);
                n5_d = 72'(r4_gg);
            end
            SEL_FLAT: begin
                n5_p = 64'(i_cfg.gain);
                n5_d = 72'(r4_wr) * 72'(EPS);
            end
            default: begin
                n5_p = r4_gf;
                n5_d = 72'(r4_wr) * 72'(EPS);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_p    <= n5_p;
            r5_d    <= n5_d;
            r5_vneg <= r4_vneg;
            r5_dneg <= r4_dneg;
        end
    end

    // Stage 6: overflow test; a zero numerator divides by all ones to give 0.
    logic [DEN_W-1:0] r_rem  [QUO_W+1];
    logic [DEN_W-1:0] r_den  [QUO_W+1];
    logic [QUO_W-1:0] r_quo  [QUO_W+1];
    logic             r_over [QUO_W+1];
    logic             r_vneg [QUO_W+1];
    logic             r_dneg [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= 72'(r5_p);
            r_den[0]  <= (r5_p == '0) ? '1 : r5_d;
            r_quo[0]  <= '0;
            r_over[0] <= (r5_p != '0) && (72'(r5_p) >= r5_d);
            r_vneg[0] <= r5_vneg;
            r_dneg[0] <= r5_dneg;
        end
    end

    // Divider: each stage shifts the remainder and takes one quotient bit.
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        logic [DEN_W:0] n_t;
        logic           n_ge;

        assign n_t  = {r_rem[k], 1'b0};
        assign n_ge = n_t >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? 72'(n_t - {1'b0, r_den[k]}) : n_t[DEN_W-1:0];
                r_den[k+1]  <= r_den[k];
                r_quo[k+1]  <= {r_quo[k][QUO_W-2:0], n_ge};
                r_over[k+1] <= r_over[k];
                r_vneg[k+1] <= r_vneg[k];
                r_dneg[k+1] <= r_dneg[k];
            end
        end
    end

    // Output stage: saturate the magnitude and apply the push direction.
    logic        n_pneg, n_sat;
    logic [32:0] n_lim, n_mag;
    logic [31:0] r_push;
    logic        r_clip;

    assign n_pneg = !r_dneg[QUO_W] ^ r_vneg[QUO_W];
    assign n_lim  = n_pneg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    assign n_sat  = r_over[QUO_W] || ({1'b0, r_quo[QUO_W]} > n_lim);
    assign n_mag  = n_sat ? n_lim : {1'b0, r_quo[QUO_W]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_push <= n_pneg ? (32'd0 - n_mag[31:0]) : n_mag[31:0];
            r_clip <= n_sat;
        end
    end

    assign o_push = $signed(r_push);
    assign o_clip = r_clip;

endmodule

[rtl/geofence_barrier_velocity.sv]
// ----------------------------------------------------------------------------
// geofence_barrier_velocity
// Geofence barrier velocity command for the x and y axes of a planar vehicle.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_stall) carries one beat per odometry sample:
// position and velocity on x and y in signed Q16.16. The output channel
// (o_valid, i_stall) returns one beat per input beat, in order, with the push
// command per axis and a flag that is set when either axis saturated.
// The block takes one beat per cycle while the receiver does not stall. It has
// one stage for the prediction multiply, four for the region test and products,
// one for the overflow test, 32 divider stages at one quotient bit each, one output stage.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_stall rises in the same cycle; nothing is dropped or repeated.
// The configuration channel (i_cfg_valid, o_cfg_ready) is always ready and
// writes one register per beat; write it only while the pipeline is empty.
// Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module geofence_barrier_velocity (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [31:0]                i_pos_x,
    input  logic signed [31:0]                i_pos_y,
    input  logic signed [31:0]                i_vel_x,
    input  logic signed [31:0]                i_vel_y,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_push_x,
    output logic signed [31:0]                o_push_y,
    output logic                              o_clipped,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gbv_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import gbv_pkg::*;

    // Configuration registers.
    logic [LA_W-1:0]  r_lookahead;
    logic [REG_W-1:0] r_centre_x, r_centre_y, r_half_w, r_inner, r_outer;
    logic [REG_W-1:0] r_gain_x, r_gain_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead <= 20'd13107;
            r_centre_x  <= 31'd655360;
            r_centre_y  <= 31'd655360;
            r_half_w    <= 31'd655360;
            r_inner     <= 31'd26214;
            r_outer     <= 31'd65536;
            r_gain_x    <= 31'd65536;
            r_gain_y    <= 31'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                IDX_LOOKAHEAD: r_lookahead <= i_cfg_data[LA_W-1:0];
                IDX_CENTRE_X:  r_centre_x  <= i_cfg_data[REG_W-1:0];
                IDX_CENTRE_Y:  r_centre_y  <= i_cfg_data[REG_W-1:0];
                IDX_HALF_W:    r_half_w    <= i_cfg_data[REG_W-1:0];
                IDX_INNER:     r_inner     <= i_cfg_data[REG_W-1:0];
                IDX_OUTER:     r_outer     <= i_cfg_data[REG_W-1:0];
                IDX_GAIN_X:    r_gain_x    <= i_cfg_data[REG_W-1:0];
                default:       r_gain_y    <= i_cfg_data[REG_W-1:0];
            endcase
        end
    end

    t_axis_cfg cfg_x, cfg_y;

    assign cfg_x = '{lookahead: r_lookahead, centre: r_centre_x, half_width: r_half_w,
                     inner: r_inner, outer: r_outer, gain: r_gain_x};
    assign cfg_y = '{lookahead: r_lookahead, centre: r_centre_y, half_width: r_half_w,
                     inner: r_inner, outer: r_outer, gain: r_gain_y};

    // The pipeline advances unless the output beat is held by the receiver.
    logic           en;
    logic [LAT-1:0] r_v;

    assign en      = !(r_v[LAT-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-2:0], i_valid};
        end
    end

    // Both axes run side by side on the same enable.
    logic clip_x, clip_y;

    gbv_axis u_axis_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cfg  (cfg_x),
        .i_pos  (i_pos_x),
        .i_vel  (i_vel_x),
        .o_push (o_push_x),
        .o_clip (clip_x)
    );

    gbv_axis u_axis_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cfg  (cfg_y),
        .i_pos  (i_pos_y),
        .i_vel  (i_vel_y),
        .o_push (o_push_y),
        .o_clip (clip_y)
    );

    assign o_valid   = r_v[LAT-1];
    assign o_clipped = clip_x | clip_y;

`ifndef SYNTHESIS
    // A flagged beat carries at least one push at a saturation limit.
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_push_x == 32'sh7FFF_FFFF || o_push_x == 32'sh8000_0000 ||
             o_push_y == 32'sh7FFF_FFFF || o_push_y == 32'sh8000_0000))
        else $error("clipped beat without a saturated push");

    // A beat in the next to last stage reaches the output on an advance.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v[LAT-2]) |=> o_valid)
        else $error("beat lost before the output stage");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

[tb/sv/tb_geofence_barrier_velocity.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_geofence_barrier_velocity
// Self-checking bench for the geofence barrier velocity block. A directed
// table (extremes, zero gain, a fence as narrow as the inner radius) is walked
// first. Several register settings then follow with random odometry beats.
// Every result beat is checked field by field against an in-bench predictor or
// a typed expectation, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_geofence_barrier_velocity;
    import gbv_pkg::*;

    localparam int WATCHDOG = 5000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       data;
        logic signed [31:0] px, py, vx, vy;
        bit                typed;
        logic [31:0]       ex, ey;
        logic              ec;
    } t_row;

    typedef struct {
        logic [31:0] push_x;
        logic [31:0] push_y;
        logic        clipped;
    } t_push;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_vel_x = '0, i_vel_y = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_push_x, o_push_y;
    logic               o_clipped;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    logic [31:0] fence_cfg [8];
    t_push       push_q [$];
    t_row        dir_tab [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          calm = 0;
    int          stall_left = 0;

    geofence_barrier_velocity i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predicted push of one axis under the mirrored register settings.
    function automatic logic [31:0] axis_push(input logic signed [31:0] pos, vel,
                                              input logic [31:0] centre, gain,
                                              inout bit clip);
        longint p, d, a, h, r, rh, rm, ra, e;
        longint unsigned mag, limit, prod, w, den2, g, gn;
        bit [127:0] num, q;
        bit over, vneg, pneg;
        rh = longint'({32'b0, fence_cfg[IDX_HALF_W]});
        rm = longint'({32'b0, fence_cfg[IDX_INNER]});
        ra = longint'({32'b0, fence_cfg[IDX_OUTER]});
        e = longint'(EPS);
        gn = {32'b0, gain};
        p = longint'(pos) + ((longint'({32'b0, fence_cfg[IDX_LOOKAHEAD]}) * longint'(vel)) >>> 16);
        d = p - longint'({32'b0, centre});
        a = d < 0 ? -d : d;
        h = rh - a;
        r = rh - rm;
        mag = 0; over = 0; vneg = 0; w = 1;
        if (h > ra) begin
            mag = 0;
        end else if (r >= a + e) begin
            g = longint'(r - a);
            mag = (gn << 32) / (g * g);
        end else begin
            if (h < rm || ra <= rm) begin
                prod = gn;
            end else begin
                prod = gn * longint'(2 * a + e + ra - rh);
                w = longint'(ra - rm);
            end
            num = {64'b0, prod} << 32;
            vneg = (r < 0);
            den2 = longint'(r < 0 ? -r : r) * longint'(e);
            if (den2 == 0) begin
                over = (prod != 0);
            end else begin
                q = (num / {64'b0, w}) / {64'b0, den2};
                if (q[127:64] != 0) over = 1;
                else mag = q[63:0];
            end
        end
        pneg = ((d >= 0) != vneg);
        limit = pneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (over || mag > limit) begin
            mag = limit;
            clip = 1;
        end
        return pneg ? 32'(0 - mag) : 32'(mag);
    endfunction

    function automatic t_push predict_push(input logic signed [31:0] px, py, vx, vy);
        t_push r;
        bit clip;
        clip = 0;
        r.push_x = axis_push(px, vx, fence_cfg[IDX_CENTRE_X], fence_cfg[IDX_GAIN_X], clip);
        r.push_y = axis_push(py, vy, fence_cfg[IDX_CENTRE_Y], fence_cfg[IDX_GAIN_Y], clip);
        r.clipped = clip;
        return r;
    endfunction

    // Register write, only once the pipeline has drained.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        while (push_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        fence_cfg[idx] = (idx == IDX_LOOKAHEAD) ? (data & 32'h000F_FFFF) : (data & 32'h7FFF_FFFF);
    endtask

    task automatic set_fence(input logic [31:0] la, cx, cy, hw, rin, rout, gx, gy);
        write_reg(IDX_LOOKAHEAD, la);
        write_reg(IDX_CENTRE_X, cx);
        write_reg(IDX_CENTRE_Y, cy);
        write_reg(IDX_HALF_W, hw);
        write_reg(IDX_INNER, rin);
        write_reg(IDX_OUTER, rout);
        write_reg(IDX_GAIN_X, gx);
        write_reg(IDX_GAIN_Y, gy);
    endtask

    // Send one odometry beat; the expectation is queued once it is accepted.
    task automatic send_beat(input logic signed [31:0] px, py, vx, vy,
                             input bit typed, input t_push typed_push);
        if (!calm && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_vel_x <= vx;
        i_vel_y <= vy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        push_q.push_back(typed ? typed_push : predict_push(px, py, vx, vy));
    endtask

    // One random position about a centre, mostly within reach of the fence.
    function automatic logic [31:0] near_pos(input logic [31:0] centre);
        longint span, off;
        span = longint'({32'b0, fence_cfg[IDX_HALF_W]}) + longint'({32'b0, fence_cfg[IDX_OUTER]}) + 2;
        off = longint'({$urandom, $urandom} % 64'(2 * span + 1)) - span;
        return 32'(longint'({32'b0, centre}) + off);
    endfunction

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'($urandom_range(0, 2 * 65536 * 16)) - 32'd1048576;
            2: return 32'($urandom_range(0, 65536)) - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_beats(input int n);
        t_push none;
        none = '{32'd0, 32'd0, 1'b0};
        repeat (n) begin
            if ($urandom_range(9) == 0)
                send_beat($urandom, $urandom, $urandom, $urandom, 0, none);
            else
                send_beat(near_pos(fence_cfg[IDX_CENTRE_X]), near_pos(fence_cfg[IDX_CENTRE_Y]),
                          rand_vel(), rand_vel(), 0, none);
        end
    endtask

    // Receiver stall bursts.
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(4) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        t_push want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (push_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat x=%h y=%h c=%b",
                                               o_push_x, o_push_y, o_clipped);
            end else begin
                want = push_q.pop_front();
                if (o_push_x !== want.push_x || o_push_y !== want.push_y ||
                    o_clipped !== want.clipped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected x=%h y=%h c=%b, got x=%h y=%h c=%b",
                                 want.push_x, want.push_y, want.clipped,
                                 o_push_x, o_push_y, o_clipped);
                end
            end
        end
    end

    // Watchdog on cycles with no beat on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready) ||
            !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_row  rw;
        t_push tp;
        fence_cfg[IDX_LOOKAHEAD] = 32'd13107;
        fence_cfg[IDX_CENTRE_X] = 32'd655360;
        fence_cfg[IDX_CENTRE_Y] = 32'd655360;
        fence_cfg[IDX_HALF_W] = 32'd655360;
        fence_cfg[IDX_INNER] = 32'd26214;
        fence_cfg[IDX_OUTER] = 32'd65536;
        fence_cfg[IDX_GAIN_X] = 32'd65536;
        fence_cfg[IDX_GAIN_Y] = 32'd65536;

        // Directed rows under the reset settings, then zero gain and a
        // fence exactly as narrow as the inner radius.
        dir_tab.push_back('{ROW_ITEM, 0, 0, 655360, 655360, 0, 0, 1, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 655360, 655360, 32'h7FFFFFFF, 32'h80000000,
                            0, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                            0, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 655360 + 629146, 655360 - 629146, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 655360 - 600000, 655360 + 600000, 65536, -65536,
                            0, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 655360 + 620000, 655360 - 640000, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, IDX_GAIN_X, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, IDX_GAIN_Y, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 655360 + 629146, 32'h80000000, 0, 0, 1, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, IDX_HALF_W, 65536, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, IDX_INNER, 65536, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, IDX_OUTER, 131072, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, IDX_GAIN_X, 65536, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, IDX_GAIN_Y, 65536, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 655360, 655360, 0, 0,
                            1, 32'h80000000, 32'h80000000, 1});
        dir_tab.push_back('{ROW_ITEM, 0, 0, 655360 + 30000, 655360 - 30000, 0, 0, 0, 0, 0, 0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            rw = dir_tab[k];
            if (rw.kind == ROW_CFG) begin
                i_valid <= 1'b0;
                write_reg(rw.idx, rw.data);
            end else begin
                tp = '{rw.ex, rw.ey, rw.ec};
                send_beat(rw.px, rw.py, rw.vx, rw.vy, rw.typed, tp);
            end
        end
        i_valid <= 1'b0;

        // Fixed settings: defaults, zero lookahead and gain, extremes, zero
        // ramp width, outer below inner, fence narrower than inner, tiny fence.
        set_fence(13107, 655360, 655360, 655360, 26214, 65536, 65536, 65536);
        random_beats(60);
        i_valid <= 1'b0;
        set_fence(0, 131072, 0, 327680, 13107, 98304, 0, 196608);
        random_beats(50);
        i_valid <= 1'b0;
        set_fence(32'hFFFFFFFF, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF);
        random_beats(50);
        i_valid <= 1'b0;
        set_fence(6554, 655360, 655360, 262144, 131072, 131072, 65536, 655360);
        random_beats(60);
        i_valid <= 1'b0;
        set_fence(655360, 655360, 655360, 262144, 131072, 65536, 65536, 65536);
        random_beats(60);
        i_valid <= 1'b0;
        set_fence(13107, 655360, 655360, 65536, 131072, 196608, 65536, 65536);
        random_beats(60);
        i_valid <= 1'b0;
        set_fence(13107, 0, 0, 1000, 0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
        random_beats(60);
        i_valid <= 1'b0;

        // Random settings; the last one runs without idling.
        for (int ph = 0; ph < 5; ph++) begin
            logic [31:0] hw, rin, rout;
            hw = $urandom_range(1000, 32'h00FFFFFF);
            rin = $urandom_range(0, hw + 65536);
            rout = rin + $urandom_range(0, 262144);
            set_fence($urandom_range(0, 655360), $urandom_range(0, 32'h0FFFFFFF),
                      $urandom_range(0, 32'h0FFFFFFF), hw, rin, rout,
                      $urandom_range(0, 32'h00FFFFFF), $urandom & 32'h7FFFFFFF);
            if (ph == 4) calm = 1;
            random_beats(80);
            i_valid <= 1'b0;
        end

        while (push_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (mismatches == 0 && push_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
